FILE: hdl/agpr_pkg.sv
// agpr_pkg: shared types, register indexes and colour helpers for the glyph renderer
// depends on nothing; imported by the front, back and top level
`timescale 1ns / 1ps

package agpr_pkg;

   localparam logic [1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [1:0] CSR_LOW        = 2'd1;
   localparam logic [1:0] CSR_BACKGROUND = 2'd2;

   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;

   localparam logic [23:0] FOREGROUND_RESET = 24'hFFFFFF;
   localparam logic [23:0] LOW_RESET        = 24'h000000;
   localparam logic [23:0] BACKGROUND_RESET = 24'h000000;

   localparam logic [7:0] FULL_ALPHA = 8'hFF;

   typedef struct packed {
      logic       start;
      logic       zero_size;
      logic [7:0] width;
      logic [7:0] height;
      logic [1:0] depth;
      logic       packed_rows;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [7:0]  col;
      logic [7:0]  row;
      logic [23:0] color;
      logic        write;
      logic        last;
      logic        done;
   } pixel_type;

   function automatic logic [7:0] mask_of(input logic [1:0] depth);
      logic [7:0] m;
      case (depth)
         DEPTH_1BPP: m = 8'h80;
         DEPTH_2BPP: m = 8'hC0;
         DEPTH_4BPP: m = 8'hF0;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] hi, input logic [7:0] lo,
                                              input logic [7:0] alpha);
      logic [8:0]  h;
      logic [8:0]  l;
      logic [16:0] s;
      h = {hi, 1'b1};
      l = {lo, 1'b1};
      s = 17'(h) * 17'(alpha) + 17'(l) * 17'(FULL_ALPHA - alpha);
      return s[16:9];
   endfunction

endpackage

FILE: hdl/antialiased_glyph_pixel_renderer_unit.sv
// antialiased_glyph_pixel_renderer_unit: top level of the anti-aliased glyph renderer
// depends on agpr_pkg, agpr_fifo, agpr_front and agpr_back
//
// channel  | ports                         | moves
// ---------+-------------------------------+-------------------------------------
// request  | req_push / req_full           | one bitmap byte, optional glyph start
// response | rsp_pop / rsp_empty           | one pixel transaction
// csr      | csr_valid / csr_ready         | one colour register write
//
// a byte gives one pixel per cycle while the response queue is not full, and at most
// 8 >> bits_per_pixel_code pixels, fewer at a row or glyph end; a byte with no pixel is dropped
// the back end takes the next queued byte in the cycle of the last pixel of the current one
// synchronous active-high reset empties both queues and leaves no glyph active
// a full response queue stalls the back end; the request queue then fills and raises req_full
`timescale 1ns / 1ps

module antialiased_glyph_pixel_renderer_unit #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_glyph_start,
   input  logic [7:0]  req_glyph_width,
   input  logic [7:0]  req_glyph_height,
   input  logic [1:0]  req_bits_per_pixel_code,
   input  logic        req_rows_packed,
   input  logic [7:0]  req_bitmap_byte,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_pixel_col,
   output logic [7:0]  rsp_pixel_row,
   output logic [23:0] rsp_pixel_color,
   output logic        rsp_pixel_write,
   output logic        rsp_last_of_byte,
   output logic        rsp_glyph_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import agpr_pkg::*;

   logic      mid_push, mid_full, mid_pop, mid_empty;
   item_type  front_item, mid_item;
   logic      out_push, out_full;
   pixel_type back_pixel, rsp_pixel;

   agpr_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_glyph_start         (req_glyph_start),
      .req_glyph_width         (req_glyph_width),
      .req_glyph_height        (req_glyph_height),
      .req_bits_per_pixel_code (req_bits_per_pixel_code),
      .req_rows_packed         (req_rows_packed),
      .req_bitmap_byte         (req_bitmap_byte),
      .mid_full                (mid_full),
      .mid_push                (mid_push),
      .mid_item                (front_item)
   );

   agpr_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   agpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_pixel (back_pixel)
   );

   agpr_fifo #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_pixel),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_pixel),
      .empty     (rsp_empty)
   );

   assign rsp_pixel_col    = rsp_pixel.col;
   assign rsp_pixel_row    = rsp_pixel.row;
   assign rsp_pixel_color  = rsp_pixel.color;
   assign rsp_pixel_write  = rsp_pixel.write;
   assign rsp_last_of_byte = rsp_pixel.last;
   assign rsp_glyph_done   = rsp_pixel.done;

endmodule

FILE: hdl/agpr_fifo.sv
// agpr_fifo: small register queue with push/full and pop/empty sides
// standalone; used between front and back and on the pixel output
`timescale 1ns / 1ps

module agpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/agpr_front.sv
// agpr_front: input register that accepts request transactions and classifies them
// depends on agpr_pkg; feeds the queue in front of agpr_back
`timescale 1ns / 1ps

module agpr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_glyph_start,
   input  logic [7:0]         req_glyph_width,
   input  logic [7:0]         req_glyph_height,
   input  logic [1:0]         req_bits_per_pixel_code,
   input  logic               req_rows_packed,
   input  logic [7:0]         req_bitmap_byte,
   input  logic               mid_full,
   output logic               mid_push,
   output agpr_pkg::item_type mid_item
);
   import agpr_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_full = valid_ff && mid_full;
   assign accept   = req_push && !req_full;
   assign mid_push = valid_ff;
   assign mid_item = item_ff;

   always_comb begin
      valid_in = accept || (valid_ff && mid_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // start with zero width or height finishes the glyph at once
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.start       <= req_glyph_start;
         item_ff.zero_size   <= req_glyph_start &&
                                (req_glyph_width == '0 || req_glyph_height == '0);
         item_ff.width       <= req_glyph_width;
         item_ff.height      <= req_glyph_height;
         item_ff.depth       <= req_bits_per_pixel_code;
         item_ff.packed_rows <= req_rows_packed;
         item_ff.data        <= req_bitmap_byte;
      end
   end

endmodule

FILE: hdl/agpr_back.sv
// agpr_back: glyph state, byte unpacker and alpha blender, one pixel per cycle unless out_full
// depends on agpr_pkg; holds the colour registers written over the csr port
`timescale 1ns / 1ps

module agpr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                mid_empty,
   input  agpr_pkg::item_type  mid_item,
   output logic                mid_pop,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_data,
   input  logic                out_full,
   output logic                out_push,
   output agpr_pkg::pixel_type out_pixel
);
   import agpr_pkg::*;

   logic [23:0] fg_ff, low_ff, bg_ff;

   logic [7:0] width_ff, width_in;
   logic [7:0] height_ff, height_in;
   logic [1:0] depth_ff, depth_in;
   logic       packed_ff, packed_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic       finished_ff, finished_in;
   logic       busy_ff, busy_in;
   logic [7:0] bits_ff, bits_in;
   logic [2:0] count_ff, count_in;

   logic [7:0]  mask;
   logic [7:0]  cov;
   logic [7:0]  alpha;
   logic [3:0]  shift;
   logic [2:0]  per_last;
   logic [8:0]  col_inc;
   logic [8:0]  row_inc;
   logic        row_end;
   logic        glyph_end;
   logic        stop;
   logic        emit;
   logic [23:0] color;
   logic        write;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff  <= FOREGROUND_RESET;
         low_ff <= LOW_RESET;
         bg_ff  <= BACKGROUND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOREGROUND: fg_ff  <= csr_data;
            CSR_LOW:        low_ff <= csr_data;
            CSR_BACKGROUND: bg_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mask      = mask_of(depth_ff);
      cov       = bits_ff & mask;
      alpha     = cov + (FULL_ALPHA - mask);
      shift     = 4'd1 << depth_ff;
      per_last  = 3'((4'd8 >> depth_ff) - 4'd1);
      col_inc   = {1'b0, col_ff} + 9'd1;
      row_inc   = {1'b0, row_ff} + 9'd1;
      row_end   = col_inc >= {1'b0, width_ff};
      glyph_end = row_end && (row_inc >= {1'b0, height_ff});
      stop      = glyph_end || (row_end && !packed_ff) || (count_ff == per_last);

      if (cov != '0) begin
         write = 1'b1;
         if (depth_ff == DEPTH_1BPP || fg_ff == low_ff || alpha == FULL_ALPHA) begin
            color = fg_ff;
         end else begin
            color = {mix_channel(fg_ff[23:16], low_ff[23:16], alpha),
                     mix_channel(fg_ff[15:8], low_ff[15:8], alpha),
                     mix_channel(fg_ff[7:0], low_ff[7:0], alpha)};
         end
      end else begin
         color = bg_ff;
         write = (fg_ff != bg_ff);
      end

      emit = busy_ff && !out_full;

      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      packed_in   = packed_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      finished_in = finished_ff;
      busy_in     = busy_ff;
      bits_in     = bits_ff;
      count_in    = count_ff;

      if (emit) begin
         bits_in  = bits_ff << shift;
         count_in = count_ff + 1'b1;
         if (row_end) begin
            col_in = '0;
            row_in = row_inc[7:0];
         end else begin
            col_in = col_inc[7:0];
         end
         if (glyph_end) begin
            finished_in = 1'b1;
         end
         if (stop) begin
            busy_in = 1'b0;
         end
      end

      // next byte is taken while the last pixel of this one goes out
      mid_pop = !mid_empty && (!busy_ff || (emit && stop));

      if (mid_pop) begin
         if (mid_item.start) begin
            width_in    = mid_item.width;
            height_in   = mid_item.height;
            depth_in    = mid_item.depth;
            packed_in   = mid_item.packed_rows;
            col_in      = '0;
            row_in      = '0;
            finished_in = mid_item.zero_size;
         end
         bits_in  = mid_item.data;
         count_in = '0;
         busy_in  = !finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= '0;
         height_ff   <= '0;
         depth_ff    <= '0;
         packed_ff   <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         finished_ff <= 1'b1;
         busy_ff     <= 1'b0;
         count_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         packed_ff   <= packed_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         finished_ff <= finished_in;
         busy_ff     <= busy_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   assign out_push        = emit;
   assign out_pixel.col   = col_ff;
   assign out_pixel.row   = row_ff;
   assign out_pixel.color = color;
   assign out_pixel.write = write;
   assign out_pixel.last  = stop;
   assign out_pixel.done  = glyph_end;

endmodule

FILE: hdl/agpr_checker.sv
// agpr_checker: port-level assertions for the glyph renderer, with its bind
// depends on antialiased_glyph_pixel_renderer_unit port names only
`timescale 1ns / 1ps

module agpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_pop,
   input logic        rsp_empty,
   input logic [7:0]  rsp_pixel_col,
   input logic [7:0]  rsp_pixel_row,
   input logic [23:0] rsp_pixel_color,
   input logic        rsp_pixel_write,
   input logic        rsp_last_of_byte,
   input logic        rsp_glyph_done
);

   // reset leaves no response waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // reset leaves the request side open
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // final pixel of a glyph also ends its byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_glyph_done) |-> rsp_last_of_byte)
      else $error("glyph done without last of byte");

   // a waiting response transaction holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_col) &&
      $stable(rsp_pixel_row) && $stable(rsp_pixel_color) && $stable(rsp_pixel_write) &&
      $stable(rsp_last_of_byte) && $stable(rsp_glyph_done)))
      else $error("waiting response changed before pop");

endmodule

bind antialiased_glyph_pixel_renderer_unit agpr_checker u_agpr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_pop          (rsp_pop),
   .rsp_empty        (rsp_empty),
   .rsp_pixel_col    (rsp_pixel_col),
   .rsp_pixel_row    (rsp_pixel_row),
   .rsp_pixel_color  (rsp_pixel_color),
   .rsp_pixel_write  (rsp_pixel_write),
   .rsp_last_of_byte (rsp_last_of_byte),
   .rsp_glyph_done   (rsp_glyph_done)
);

FILE: test/tb_antialiased_glyph_pixel_renderer_unit.sv
// tb_antialiased_glyph_pixel_renderer_unit: self-checking bench for the glyph pixel renderer
// drives bitmap bytes and colour writes, predicts or lists every pixel and checks them in order
// depends on agpr_pkg and antialiased_glyph_pixel_renderer_unit
`timescale 1ns / 1ps

module tb_antialiased_glyph_pixel_renderer_unit;
   import agpr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 35;

   typedef struct packed {
      bit       start;
      bit [7:0] width;
      bit [7:0] height;
      bit [1:0] bpp_code;
      bit       rows_packed;
      bit [7:0] bitmap;
   } byte_item_type;

   typedef struct packed {
      bit [7:0]  col;
      bit [7:0]  row;
      bit [23:0] color;
      bit        write_en;
      bit        last_byte;
      bit        glyph_end;
   } pixel_rec_type;

   typedef struct {
      byte_item_type item;
      int            typed_n;
      pixel_rec_type typed_px;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_glyph_start = 1'b0;
   logic [7:0]  req_glyph_width = 8'd0;
   logic [7:0]  req_glyph_height = 8'd0;
   logic [1:0]  req_bits_per_pixel_code = 2'd0;
   logic        req_rows_packed = 1'b0;
   logic [7:0]  req_bitmap_byte = 8'd0;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [7:0]  rsp_pixel_col;
   logic [7:0]  rsp_pixel_row;
   logic [23:0] rsp_pixel_color;
   logic        rsp_pixel_write;
   logic        rsp_last_of_byte;
   logic        rsp_glyph_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_FOREGROUND;
   logic [23:0] csr_data = 24'd0;

   // predictor copy of colours and glyph position
   logic [23:0] fg_color = FOREGROUND_RESET;
   logic [23:0] low_color = LOW_RESET;
   logic [23:0] bg_color = BACKGROUND_RESET;
   logic [7:0]  draw_col = 8'd0;
   logic [7:0]  draw_row = 8'd0;
   logic [7:0]  glyph_w = 8'd0;
   logic [7:0]  glyph_h = 8'd0;
   logic [1:0]  glyph_depth = 2'd0;
   logic        glyph_rows_packed = 1'b0;
   logic        glyph_idle = 1'b1;

   pixel_rec_type expected_pixels[$];
   pixel_rec_type byte_pixels[$];
   stim_row_type  directed_rows[$];
   int            mismatch_count = 0;
   int            counted_items = 0;
   int            phase_target = 0;
   int            cycle_count = 0;
   int            send_gap_max = 18;
   int            pop_stall_max = 18;

   antialiased_glyph_pixel_renderer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_glyph_start(req_glyph_start),
      .req_glyph_width(req_glyph_width),
      .req_glyph_height(req_glyph_height),
      .req_bits_per_pixel_code(req_bits_per_pixel_code),
      .req_rows_packed(req_rows_packed),
      .req_bitmap_byte(req_bitmap_byte),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_pixel_col(rsp_pixel_col),
      .rsp_pixel_row(rsp_pixel_row),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_pixel_write(rsp_pixel_write),
      .rsp_last_of_byte(rsp_last_of_byte),
      .rsp_glyph_done(rsp_glyph_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("antialiased_glyph_pixel_renderer_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [7:0] blend_channel(input logic [7:0] hi, input logic [7:0] lo,
                                                input logic [7:0] alpha);
      int unsigned hw;
      int unsigned lw;
      hw = 2 * hi + 1;
      lw = 2 * lo + 1;
      return 8'((hw * alpha + lw * (255 - alpha)) >> 9);
   endfunction

   function automatic logic [23:0] covered_shade(input logic [7:0] cov, input logic [7:0] mask);
      logic [7:0] alpha;
      alpha = 8'(cov + 255 - mask);
      if (glyph_depth == DEPTH_1BPP || fg_color == low_color || alpha == 8'hFF)
         return fg_color;
      return {blend_channel(fg_color[23:16], low_color[23:16], alpha),
              blend_channel(fg_color[15:8], low_color[15:8], alpha),
              blend_channel(fg_color[7:0], low_color[7:0], alpha)};
   endfunction

   // unpacks one accepted byte into byte_pixels and advances the glyph position
   task automatic render_byte(input byte_item_type it);
      logic [7:0]    bits;
      logic [7:0]    mask;
      logic [7:0]    cov;
      int            per_byte;
      pixel_rec_type px;
      byte_pixels.delete();
      if (it.start) begin
         glyph_w = it.width;
         glyph_h = it.height;
         glyph_depth = it.bpp_code;
         glyph_rows_packed = it.rows_packed;
         draw_col = 8'd0;
         draw_row = 8'd0;
         glyph_idle = (it.width == 8'd0 || it.height == 8'd0);
      end
      if (glyph_idle)
         return;
      bits = it.bitmap;
      mask = 8'hFF << (8 - (1 << glyph_depth));
      per_byte = 8 >> glyph_depth;
      for (int k = 0; k < per_byte; k++) begin
         cov = bits & mask;
         px = '0;
         px.col = draw_col;
         px.row = draw_row;
         if (cov != 8'd0) begin
            px.color = covered_shade(cov, mask);
            px.write_en = 1'b1;
         end else begin
            px.color = bg_color;
            px.write_en = (fg_color != bg_color);
         end
         bits = bits << (1 << glyph_depth);
         draw_col = draw_col + 8'd1;
         if (draw_col >= glyph_w) begin
            draw_col = 8'd0;
            draw_row = draw_row + 8'd1;
            if (draw_row >= glyph_h) begin
               glyph_idle = 1'b1;
               px.glyph_end = 1'b1;
               px.last_byte = 1'b1;
            end else if (!glyph_rows_packed) begin
               px.last_byte = 1'b1;
            end
         end
         if (k == per_byte - 1)
            px.last_byte = 1'b1;
         byte_pixels.push_back(px);
         if (px.last_byte)
            break;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      mismatch_count++;
      $display("%0t ns: pixel error, %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // typed_n below zero means the predictor supplies the expected pixels
   task automatic send_item(input byte_item_type it, input int typed_n,
                            input pixel_rec_type typed_px);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_glyph_start <= it.start;
      req_glyph_width <= it.width;
      req_glyph_height <= it.height;
      req_bits_per_pixel_code <= it.bpp_code;
      req_rows_packed <= it.rows_packed;
      req_bitmap_byte <= it.bitmap;
      @(negedge clock);
      while (req_full) @(negedge clock);
      render_byte(it);
      if (typed_n >= 0) begin
         if (typed_n > 0)
            expected_pixels.push_back(typed_px);
      end else begin
         foreach (byte_pixels[i]) expected_pixels.push_back(byte_pixels[i]);
      end
      if (it.start || byte_pixels.size() != 0)
         counted_items++;
      @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input logic [1:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      case (idx)
         CSR_FOREGROUND: fg_color = value;
         CSR_LOW:        low_color = value;
         CSR_BACKGROUND: bg_color = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_colors(input logic [23:0] fg, input logic [23:0] low,
                               input logic [23:0] bg);
      put_csr(CSR_FOREGROUND, fg);
      put_csr(CSR_LOW, low);
      put_csr(CSR_BACKGROUND, bg);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(input bit st, input int w, input int h, input int bpp, input bit pk,
                          input logic [7:0] data, input int n, input logic [23:0] color,
                          input bit wr);
      stim_row_type r;
      r.item = '{start: st, width: 8'(w), height: 8'(h), bpp_code: 2'(bpp),
                 rows_packed: pk, bitmap: data};
      r.typed_n = n;
      r.typed_px = '{col: 8'd0, row: 8'd0, color: color, write_en: wr,
                     last_byte: 1'b1, glyph_end: 1'b1};
      directed_rows.push_back(r);
   endtask

   function automatic logic [7:0] pick_bitmap();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic byte_item_type random_item(input bit st);
      byte_item_type it;
      it.start = st;
      it.width = 8'($urandom);
      it.height = 8'($urandom);
      it.bpp_code = 2'($urandom);
      it.rows_packed = 1'($urandom);
      it.bitmap = pick_bitmap();
      return it;
   endfunction

   // one glyph, mostly well formed; sometimes cut short or followed by stray bytes
   task automatic random_glyph();
      byte_item_type it;
      int            shape;
      if ($urandom_range(0, 24) == 0)
         drain();
      it = random_item(1'b1);
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
         it.width = 8'($urandom_range(1, 10));
         it.height = 8'($urandom_range(1, 6));
      end else if (shape == 7) begin
         it.width = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
         it.height = 8'($urandom_range(1, 2));
         it.bpp_code = DEPTH_1BPP;
      end else begin
         it.width = 8'($urandom_range(1, 2));
         it.height = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
         it.bpp_code = DEPTH_1BPP;
         it.rows_packed = 1'b1;
      end
      send_item(it, -1, '0);
      while (!glyph_idle && counted_items < phase_target && $urandom_range(0, 79) != 0)
         send_item(random_item(1'b0), -1, '0);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_item(random_item(1'b0), -1, '0);
   endtask

   initial begin : pixel_sink
      int            stall;
      pixel_rec_type want;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, pop_stall_max);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(negedge clock);
         while (rsp_empty) @(negedge clock);
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel at col %0d row %0d",
                                      rsp_pixel_col, rsp_pixel_row), rsp_pixel_color, 24'd0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_col !== want.col)
               report_mismatch($sformatf("col at row %0d", want.row),
                               24'(rsp_pixel_col), 24'(want.col));
            if (rsp_pixel_row !== want.row)
               report_mismatch($sformatf("row at col %0d", want.col),
                               24'(rsp_pixel_row), 24'(want.row));
            if (rsp_pixel_color !== want.color)
               report_mismatch($sformatf("color at col %0d row %0d", want.col, want.row),
                               rsp_pixel_color, want.color);
            if (rsp_pixel_write !== want.write_en)
               report_mismatch($sformatf("write at col %0d row %0d", want.col, want.row),
                               24'(rsp_pixel_write), 24'(want.write_en));
            if (rsp_last_of_byte !== want.last_byte)
               report_mismatch($sformatf("last_of_byte at col %0d row %0d", want.col, want.row),
                               24'(rsp_last_of_byte), 24'(want.last_byte));
            if (rsp_glyph_done !== want.glyph_end)
               report_mismatch($sformatf("glyph_done at col %0d row %0d", want.col, want.row),
                               24'(rsp_glyph_done), 24'(want.glyph_end));
         end
         @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset colours: white on black
      add_row(1'b0, 1, 1, 3, 1'b0, 8'hFF, 0, 24'h0, 1'b0);        // no glyph active yet
      add_row(1'b1, 1, 1, 3, 1'b0, 8'hFF, 1, 24'hFFFFFF, 1'b1);   // full coverage
      add_row(1'b0, 7, 9, 2, 1'b1, 8'hAA, 0, 24'h0, 1'b0);        // glyph already done
      add_row(1'b1, 0, 5, 0, 1'b1, 8'hFF, 0, 24'h0, 1'b0);        // zero width
      add_row(1'b0, 0, 0, 0, 1'b0, 8'hFF, 0, 24'h0, 1'b0);
      add_row(1'b1, 4, 0, 1, 1'b0, 8'h55, 0, 24'h0, 1'b0);        // zero height
      add_row(1'b1, 1, 1, 3, 1'b0, 8'h00, 1, 24'h000000, 1'b1);   // uncovered
      add_row(1'b1, 1, 1, 3, 1'b1, 8'h80, -1, 24'h0, 1'b0);
      add_row(1'b1, 255, 1, 0, 1'b1, 8'hA5, -1, 24'h0, 1'b0);
      add_row(1'b0, 0, 0, 0, 1'b0, 8'hFF, -1, 24'h0, 1'b0);
      add_row(1'b0, 0, 0, 0, 1'b0, 8'h00, -1, 24'h0, 1'b0);
      add_row(1'b1, 3, 2, 1, 1'b0, 8'hE4, -1, 24'h0, 1'b0);       // row end drops bits
      add_row(1'b0, 0, 0, 0, 1'b0, 8'h1B, -1, 24'h0, 1'b0);
      add_row(1'b1, 3, 1, 2, 1'b1, 8'hF1, -1, 24'h0, 1'b0);       // glyph end mid byte
      add_row(1'b0, 0, 0, 0, 1'b0, 8'h80, -1, 24'h0, 1'b0);
      add_row(1'b1, 2, 2, 3, 1'b1, 8'h01, -1, 24'h0, 1'b0);
      add_row(1'b0, 0, 0, 0, 1'b0, 8'hFE, -1, 24'h0, 1'b0);
      add_row(1'b0, 0, 0, 0, 1'b0, 8'h7F, -1, 24'h0, 1'b0);
      add_row(1'b0, 0, 0, 0, 1'b0, 8'h40, -1, 24'h0, 1'b0);
      add_row(1'b1, 4, 4, 0, 1'b0, 8'hC3, -1, 24'h0, 1'b0);
      add_row(1'b1, 1, 255, 0, 1'b1, 8'h55, -1, 24'h0, 1'b0);    // restart mid glyph
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed_n, directed_rows[i].typed_px);
      drain();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: write_colors(24'h000000, 24'hFFFFFF, 24'h000000);
            1: write_colors(24'h3C7E99, 24'h3C7E99, 24'hFFFFFF);
            2: write_colors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            3: write_colors(24'hFF8000, 24'h0080FF, 24'h00FF00);
            default: begin
               fg_color = 24'($urandom);
               write_colors(fg_color, 24'($urandom),
                            (p == 4) ? fg_color : 24'($urandom));
            end
         endcase
         send_gap_max = (p % 2 == 0) ? 18 : 0;
         pop_stall_max = ((p / 2) % 2 == 0) ? 18 : 0;
         phase_target = counted_items + PHASE_ITEMS;
         while (counted_items < phase_target)
            random_glyph();
         drain();
      end

      if (mismatch_count == 0)
         $display("antialiased_glyph_pixel_renderer_unit: match");
      else
         $display("antialiased_glyph_pixel_renderer_unit: mismatch");
      $finish;
   end

endmodule
